>>> rtl/kufe_pkg.sv
package kufe_pkg;

  localparam int VERTEX_W = 8;
  localparam int WEIGHT_W = 16;
  localparam int SIZE_W   = 9;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_EDGE  = 1'b1;

  typedef struct packed {
    logic clear_all;
    logic touch_set;
    logic link_we;
    logic size_we;
  } store_cmd_t;

endpackage

>>> rtl/kufe_store.sv
module kufe_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kufe_pkg::store_cmd_t          cmd,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [AW-1:0]                 link_wdata,
  input  logic [kufe_pkg::SIZE_W-1:0]   size_wdata,
  output logic [AW-1:0]                 link_rdata,
  output logic [kufe_pkg::SIZE_W-1:0]   size_rdata,
  output logic                          touched_rdata
);

  logic [AW-1:0]               link_mem [DEPTH];
  logic [kufe_pkg::SIZE_W-1:0] size_mem [DEPTH];
  logic [DEPTH-1:0]            touched;

  always_ff @(posedge clk) begin
    if (cmd.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (cmd.size_we) begin
      size_mem[wr_addr] <= size_wdata;
    end
    link_rdata <= link_mem[rd_addr];
    size_rdata <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      touched <= '0;
    end else if (cmd.touch_set) begin
      touched[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    touched_rdata <= touched[rd_addr];
  end

endmodule

>>> rtl/kruskal_union_find_edge_filter_unit.sv
// Clear request: clears all touched bits, then goes to the done state. An edge walks the parent
// chain of each end to its root, one read of the link memory plus one compare per link; if the
// roots differ, the smaller set's root is linked under the other. Out-of-range edges skip to done.
// One edge is in work at a time; the next is taken once the result is in the output register.
// Synchronous active-high reset clears the sequencer, output valid and all touched bits;
// link and size memories are not cleared.
module kruskal_union_find_edge_filter_unit #(
  parameter int NUM_VERTICES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            req_type,
  input  logic [kufe_pkg::VERTEX_W-1:0]   vertex_a,
  input  logic [kufe_pkg::VERTEX_W-1:0]   vertex_b,
  input  logic [kufe_pkg::WEIGHT_W-1:0]   edge_weight,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            tree_edge,
  output logic [kufe_pkg::VERTEX_W-1:0]   end_a,
  output logic [kufe_pkg::VERTEX_W-1:0]   end_b,
  output logic [kufe_pkg::WEIGHT_W-1:0]   weight_out,
  output logic [kufe_pkg::SIZE_W-1:0]     merged_size
);

  localparam int ADDRESSABLE = 1 << kufe_pkg::VERTEX_W;
  localparam int DEPTH = (NUM_VERTICES < ADDRESSABLE) ? NUM_VERTICES : ADDRESSABLE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(NUM_VERTICES + 1);
  localparam logic [kufe_pkg::VERTEX_W:0] DEPTH_LIM = (kufe_pkg::VERTEX_W + 1)'(DEPTH);
  localparam logic [SW-1:0] STEP_LIM = SW'(NUM_VERTICES);
  localparam logic [kufe_pkg::SIZE_W-1:0] ONE_SIZE = kufe_pkg::SIZE_W'(1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_A_RD   = 4'd1;
  localparam logic [3:0] ST_A_CHK  = 4'd2;
  localparam logic [3:0] ST_B_RD   = 4'd3;
  localparam logic [3:0] ST_B_CHK  = 4'd4;
  localparam logic [3:0] ST_SA_RD  = 4'd5;
  localparam logic [3:0] ST_SB_RD  = 4'd6;
  localparam logic [3:0] ST_SB_CHK = 4'd7;
  localparam logic [3:0] ST_LINK   = 4'd8;
  localparam logic [3:0] ST_ROOT   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]                     state;
  logic [AW-1:0]                  cur;
  logic [SW-1:0]                  steps;
  logic [AW-1:0]                  ra;
  logic [AW-1:0]                  rb;
  logic [AW-1:0]                  top;
  logic [AW-1:0]                  low;
  logic [kufe_pkg::SIZE_W-1:0]    sa;
  logic [kufe_pkg::SIZE_W-1:0]    total;
  logic [kufe_pkg::VERTEX_W-1:0]  a_q;
  logic [kufe_pkg::VERTEX_W-1:0]  b_q;
  logic [kufe_pkg::WEIGHT_W-1:0]  w_q;
  logic                           res_tree;
  logic [kufe_pkg::SIZE_W-1:0]    res_merged;

  kufe_pkg::store_cmd_t           cmd;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  link_rdata;
  logic [kufe_pkg::SIZE_W-1:0]    size_rdata;
  logic                           touched_rdata;
  logic [kufe_pkg::SIZE_W-1:0]    size_sel;
  logic [kufe_pkg::SIZE_W:0]      size_sum;
  logic                           in_range;
  logic                           is_root;
  logic                           load_out;

  kufe_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .link_wdata    (top),
    .size_wdata    (total),
    .link_rdata    (link_rdata),
    .size_rdata    (size_rdata),
    .touched_rdata (touched_rdata)
  );

  assign req_stall = (state != ST_IDLE);
  assign in_range  = ({1'b0, vertex_a} < DEPTH_LIM) && ({1'b0, vertex_b} < DEPTH_LIM);
  assign is_root   = !touched_rdata || (link_rdata == cur);
  assign size_sel  = touched_rdata ? size_rdata : ONE_SIZE;
  assign size_sum  = {1'b0, sa} + {1'b0, size_sel};
  assign load_out  = (state == ST_DONE) && (!res_valid || !res_stall);

  always_comb begin
    cmd     = '0;
    rd_addr = cur;
    wr_addr = low;
    unique case (state)
      ST_IDLE: begin
        cmd.clear_all = req_valid && (req_type == kufe_pkg::REQ_CLEAR);
      end
      ST_SA_RD: begin
        rd_addr = ra;
      end
      ST_SB_RD: begin
        rd_addr = rb;
      end
      ST_LINK: begin
        cmd.link_we   = 1'b1;
        cmd.touch_set = 1'b1;
      end
      ST_ROOT: begin
        wr_addr       = top;
        cmd.link_we   = 1'b1;
        cmd.size_we   = 1'b1;
        cmd.touch_set = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (req_type == kufe_pkg::REQ_EDGE && in_range) begin
              state <= ST_A_RD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_A_RD: begin
          state <= (steps == STEP_LIM) ? ST_B_RD : ST_A_CHK;
        end
        ST_A_CHK: begin
          state <= is_root ? ST_B_RD : ST_A_RD;
        end
        ST_B_RD: begin
          if (steps == STEP_LIM) begin
            state <= (cur == ra) ? ST_DONE : ST_SA_RD;
          end else begin
            state <= ST_B_CHK;
          end
        end
        ST_B_CHK: begin
          if (is_root) begin
            state <= (cur == ra) ? ST_DONE : ST_SA_RD;
          end else begin
            state <= ST_B_RD;
          end
        end
        ST_SA_RD:  state <= ST_SB_RD;
        ST_SB_RD:  state <= ST_SB_CHK;
        ST_SB_CHK: state <= ST_LINK;
        ST_LINK:   state <= ST_ROOT;
        ST_ROOT:   state <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        a_q        <= vertex_a;
        b_q        <= vertex_b;
        w_q        <= edge_weight;
        cur        <= vertex_a[AW-1:0];
        steps      <= '0;
        res_tree   <= 1'b0;
        res_merged <= '0;
      end
      ST_A_RD: begin
        if (steps == STEP_LIM) begin
          ra    <= cur;
          cur   <= b_q[AW-1:0];
          steps <= '0;
        end
      end
      ST_A_CHK: begin
        if (is_root) begin
          ra    <= cur;
          cur   <= b_q[AW-1:0];
          steps <= '0;
        end else begin
          cur   <= link_rdata;
          steps <= steps + SW'(1);
        end
      end
      ST_B_RD: begin
        if (steps == STEP_LIM) begin
          rb <= cur;
        end
      end
      ST_B_CHK: begin
        if (is_root) begin
          rb <= cur;
        end else begin
          cur   <= link_rdata;
          steps <= steps + SW'(1);
        end
      end
      ST_SB_RD: begin
        sa <= size_sel;
      end
      ST_SB_CHK: begin
        total <= size_sum[kufe_pkg::SIZE_W-1:0];
        if (sa >= size_sel) begin
          top <= ra;
          low <= rb;
        end else begin
          top <= rb;
          low <= ra;
        end
      end
      ST_ROOT: begin
        res_tree   <= 1'b1;
        res_merged <= total;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      tree_edge   <= res_tree;
      end_a       <= a_q;
      end_b       <= b_q;
      weight_out  <= w_q;
      merged_size <= res_merged;
    end
  end

`ifndef SYNTHESIS
  a_tree_size: assert property (@(posedge clk) disable iff (rst)
    res_valid && tree_edge |-> merged_size >= kufe_pkg::SIZE_W'(2))
    else $error("tree edge with merged size below two");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !tree_edge |-> merged_size == '0)
    else $error("rejected transaction with nonzero merged size");

  a_merge_roots: assert property (@(posedge clk) disable iff (rst)
    state == ST_LINK |-> top != low)
    else $error("merge of a root under itself");

  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && req_valid && req_type == kufe_pkg::REQ_CLEAR |=> state == ST_DONE)
    else $error("clear transaction did not finish directly");
`endif

endmodule
